// File: rtl/cdq_pkg.sv
// Package for the circular deque: codes, cell command and link types, defaults.
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STAT_W    = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_RIGHT,
        OP_SHIFT_LEFT,
        OP_PUSH_REAR,
        OP_POP_REAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [WORD_W-1:0]  word;
    } t_cell_cmd;

    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  rear;
    } t_cell_link;

    typedef enum logic {
        S_IDLE,
        S_SETTLE
    } t_state;

endpackage

// File: rtl/cdq_cell.sv
// One cell of the deque row: holds one word, its valid bit and a rippled rear copy.
module cdq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdq_pkg::t_cell_cmd  i_cmd,
    input  cdq_pkg::t_cell_link i_left,
    input  cdq_pkg::t_cell_link i_right,
    output cdq_pkg::t_cell_link o_link
);

    logic                       r_valid;
    logic [cdq_pkg::WORD_W-1:0] r_word;
    logic [cdq_pkg::WORD_W-1:0] r_rear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                cdq_pkg::OP_SHIFT_RIGHT: begin
                    r_valid <= i_left.valid;
                end
                cdq_pkg::OP_SHIFT_LEFT: begin
                    r_valid <= i_right.valid;
                end
                cdq_pkg::OP_PUSH_REAR: begin
                    if (!r_valid && i_left.valid) begin
                        r_valid <= 1'b1;
                    end
                end
                cdq_pkg::OP_POP_REAR: begin
                    if (r_valid && !i_right.valid) begin
                        r_valid <= 1'b0;
                    end
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cdq_pkg::OP_SHIFT_RIGHT: begin
                r_word <= i_left.word;
            end
            cdq_pkg::OP_SHIFT_LEFT: begin
                r_word <= i_right.word;
            end
            cdq_pkg::OP_PUSH_REAR: begin
                if (!r_valid && i_left.valid) begin
                    r_word <= i_cmd.word;
                end
            end
            default: begin
                r_word <= r_word;
            end
        endcase
    end

    // The last occupied cell launches its word; every other cell passes on
    // what its right neighbor holds, so the rear word walks toward cell zero.
    always_ff @(posedge i_clk) begin
        if (r_valid && !i_right.valid) begin
            r_rear <= r_word;
        end else begin
            r_rear <= i_right.rear;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.word  = r_word;
    assign o_link.rear  = r_rear;

endmodule

// File: rtl/circular_deque_core.sv
// Top level of the circular deque: control sequencer over a row of deque cells.
//
// A request beat is taken at a rising edge with i_start high and o_busy low.
// It carries i_mode (push front, push rear, pop front, pop rear, peek front,
// peek rear) and i_push_value, used by the pushes only.
// Exactly one result beat follows per request, in the cycle right after the
// request edge: o_done is high for that one cycle with o_read_value and
// o_status. The receiver has no way to stall and must take the beat then.
// Entries sit left-justified in a row of DEPTH cells, the front in cell zero.
// Front pushes and pops shift the whole row by one cell; rear pushes and pops
// touch only the cell at the end of the occupied run.
// The rear word travels one cell per cycle back to cell zero, so after each
// request o_busy stays high until the row has settled; no new request is
// taken while o_busy is high.
// A push to a full deque reports full, a pop or peek of an empty deque
// reports empty; neither changes the contents. Unknown modes report done.
// Reset (synchronous, active low) empties the deque and drops o_busy and
// o_done; it needs no clearing pass.
module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [cdq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_push_value,
    output logic                               o_busy,
    output logic                               o_done,
    output logic signed [cdq_pkg::WORD_W-1:0]  o_read_value,
    output logic [cdq_pkg::STAT_W-1:0]         o_status
);

    localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cdq_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_done;
    logic [cdq_pkg::WORD_W-1:0]   r_read_value;
    logic [cdq_pkg::STAT_W-1:0]   r_status;

    logic                         accept;
    logic                         is_empty;
    logic                         is_full;
    cdq_pkg::t_cell_op            req_op;
    logic [cdq_pkg::WORD_W-1:0]   req_value;
    logic [cdq_pkg::STAT_W-1:0]   req_status;
    cdq_pkg::t_cell_cmd           cmd;
    cdq_pkg::t_cell_link          links [DEPTH];

    assign accept   = i_start && !o_busy;
    assign is_empty = !links[0].valid;
    assign is_full  = links[DEPTH-1].valid;

    // Decode the request against the settled row.
    always_comb begin
        req_op     = cdq_pkg::OP_HOLD;
        req_value  = '0;
        req_status = cdq_pkg::ST_DONE;
        case (i_mode)
            cdq_pkg::MODE_PUSH_FRONT: begin
                if (is_full) req_status = cdq_pkg::ST_FULL;
                else         req_op     = cdq_pkg::OP_SHIFT_RIGHT;
            end
            cdq_pkg::MODE_PUSH_REAR: begin
                if (is_full) req_status = cdq_pkg::ST_FULL;
                else         req_op     = cdq_pkg::OP_PUSH_REAR;
            end
            cdq_pkg::MODE_POP_FRONT: begin
                if (is_empty) begin
                    req_status = cdq_pkg::ST_EMPTY;
                end else begin
                    req_value = links[0].word;
                    req_op    = cdq_pkg::OP_SHIFT_LEFT;
                end
            end
            cdq_pkg::MODE_POP_REAR: begin
                if (is_empty) begin
                    req_status = cdq_pkg::ST_EMPTY;
                end else begin
                    req_value = links[0].rear;
                    req_op    = cdq_pkg::OP_POP_REAR;
                end
            end
            cdq_pkg::MODE_PEEK_FRONT: begin
                if (is_empty) req_status = cdq_pkg::ST_EMPTY;
                else          req_value  = links[0].word;
            end
            cdq_pkg::MODE_PEEK_REAR: begin
                if (is_empty) req_status = cdq_pkg::ST_EMPTY;
                else          req_value  = links[0].rear;
            end
            default: begin
                req_op = cdq_pkg::OP_HOLD;
            end
        endcase
    end

    assign cmd.op   = accept ? req_op : cdq_pkg::OP_HOLD;
    assign cmd.word = i_push_value;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdq_pkg::S_IDLE: begin
                if (accept) n_state = cdq_pkg::S_SETTLE;
            end
            cdq_pkg::S_SETTLE: begin
                if (r_cnt == '0) n_state = cdq_pkg::S_IDLE;
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        case (r_state)
            cdq_pkg::S_IDLE:   o_busy = 1'b0;
            cdq_pkg::S_SETTLE: o_busy = 1'b1;
            default:           o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= accept;
            if (accept) begin
                r_cnt <= CNT_W'(DEPTH - 1);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= req_value;
            r_status     <= req_status;
        end
    end

    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            cdq_pkg::t_cell_link left_link;
            cdq_pkg::t_cell_link right_link;

            if (gi == 0) begin : g_first
                // A virtual occupied neighbor feeds the pushed word into cell zero.
                assign left_link.valid = 1'b1;
                assign left_link.word  = i_push_value;
                assign left_link.rear  = '0;
            end else begin : g_mid
                assign left_link = links[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_link.valid = 1'b0;
                assign right_link.word  = '0;
                assign right_link.rear  = '0;
            end else begin : g_inner
                assign right_link = links[gi+1];
            end

            cdq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_left  (left_link),
                .i_right (right_link),
                .o_link  (links[gi])
            );
        end
    endgenerate

endmodule

// File: rtl/cdq_checker.sv
// Port-level checker for the circular deque, bound to the top level.
module cdq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_start,
    input logic [cdq_pkg::MODE_W-1:0]         i_mode,
    input logic                               o_busy,
    input logic                               o_done,
    input logic signed [cdq_pkg::WORD_W-1:0]  o_read_value,
    input logic [cdq_pkg::STAT_W-1:0]         o_status
);

    // Every request beat yields its result beat in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("result beat missing after request");

    // No result beat appears without a request in the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result beat without request");

    // The row needs time to settle after each request.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after request");

    // Empty status comes only from pops and peeks, with a zero word.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == cdq_pkg::ST_EMPTY) |->
        (o_read_value == '0 &&
         ($past(i_mode) == cdq_pkg::MODE_POP_FRONT ||
          $past(i_mode) == cdq_pkg::MODE_POP_REAR ||
          $past(i_mode) == cdq_pkg::MODE_PEEK_FRONT ||
          $past(i_mode) == cdq_pkg::MODE_PEEK_REAR)))
        else $error("empty status on a mode that cannot report it");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .i_mode       (i_mode),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

// File: sim/tb_circular_deque_core.sv
// Self-checking testbench for circular_deque_core: directed table, then random requests.
`timescale 1ns / 100ps

module tb_circular_deque_core;

    localparam int DEPTH     = cdq_pkg::DEPTH_DEF;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int N_RANDOM  = 1350;
    localparam int LIMIT     = 400000;
    localparam int N_SCRIPT  = 23;

    // The two mode codes the block ignores.
    localparam logic [cdq_pkg::MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [cdq_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [cdq_pkg::WORD_W-1:0] rv;
        logic [cdq_pkg::STAT_W-1:0] st;
    } t_result;

    typedef struct packed {
        logic [cdq_pkg::MODE_W-1:0] mode;
        logic [cdq_pkg::WORD_W-1:0] value;
        logic                       typed;
        logic [cdq_pkg::WORD_W-1:0] rv;
        logic [cdq_pkg::STAT_W-1:0] st;
    } t_req_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_start;
    logic [cdq_pkg::MODE_W-1:0]        i_mode;
    logic signed [cdq_pkg::WORD_W-1:0] i_push_value;
    logic                              o_busy;
    logic                              o_done;
    logic signed [cdq_pkg::WORD_W-1:0] o_read_value;
    logic [cdq_pkg::STAT_W-1:0]        o_status;

    // Expectation carried alongside the beat being offered.
    logic                              row_typed;
    logic [cdq_pkg::WORD_W-1:0]        row_rv;
    logic [cdq_pkg::STAT_W-1:0]        row_st;

    // Shadow of the deque contents.
    logic [cdq_pkg::WORD_W-1:0]        dq_store [DEPTH];
    logic [IDX_W-1:0]                  dq_head;
    logic [IDX_W-1:0]                  dq_tail;
    logic                              dq_empty;

    t_result                           pending [$];
    t_req_row                          script [N_SCRIPT];
    int                                mismatches;
    int                                cycles;

    circular_deque_core #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [IDX_W-1:0] idx_after(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_before(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Applies one request to the shadow deque and returns its result.
    function automatic t_result deque_apply(input logic [cdq_pkg::MODE_W-1:0] mode,
                                            input logic [cdq_pkg::WORD_W-1:0] word);
        t_result r;
        r.rv = '0;
        r.st = cdq_pkg::ST_DONE;
        case (mode)
            cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR: begin
                if (!dq_empty && idx_after(dq_tail) == dq_head) begin
                    r.st = cdq_pkg::ST_FULL;
                end else if (dq_empty) begin
                    dq_head = '0;
                    dq_tail = '0;
                    dq_empty = 1'b0;
                    dq_store[0] = word;
                end else if (mode == cdq_pkg::MODE_PUSH_FRONT) begin
                    dq_head = idx_before(dq_head);
                    dq_store[dq_head] = word;
                end else begin
                    dq_tail = idx_after(dq_tail);
                    dq_store[dq_tail] = word;
                end
            end
            cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR: begin
                if (dq_empty) begin
                    r.st = cdq_pkg::ST_EMPTY;
                end else begin
                    r.rv = dq_store[(mode == cdq_pkg::MODE_POP_FRONT) ? dq_head : dq_tail];
                    if (dq_head == dq_tail) begin
                        dq_empty = 1'b1;
                        dq_head = '0;
                        dq_tail = '0;
                    end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
                        dq_head = idx_after(dq_head);
                    end else begin
                        dq_tail = idx_before(dq_tail);
                    end
                end
            end
            cdq_pkg::MODE_PEEK_FRONT, cdq_pkg::MODE_PEEK_REAR: begin
                if (dq_empty)
                    r.st = cdq_pkg::ST_EMPTY;
                else
                    r.rv = dq_store[(mode == cdq_pkg::MODE_PEEK_FRONT) ? dq_head : dq_tail];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Result checking and prediction on every rising edge. A result beat
    // belongs to the request taken at the previous edge, so it is checked first.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (o_done) begin
                if (pending.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected: read_value %h status %0d",
                             $time, o_read_value, o_status);
                end else begin
                    want = pending.pop_front();
                    if (o_read_value !== want.rv) begin
                        mismatches++;
                        $display("%0t: read_value expected %h, actual %h",
                                 $time, want.rv, o_read_value);
                    end
                    if (o_status !== want.st) begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.st, o_status);
                    end
                end
            end
            if (i_start && !o_busy) begin
                want = deque_apply(i_mode, i_push_value);
                if (row_typed) begin
                    want.rv = row_rv;
                    want.st = row_st;
                end
                pending.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // Offers one request beat and returns once it has been taken.
    task automatic send_beat(input t_req_row row);
        @(negedge i_clk);
        i_start      = 1'b1;
        i_mode       = row.mode;
        i_push_value = row.value;
        row_typed    = row.typed;
        row_rv       = row.rv;
        row_st       = row.st;
        do @(posedge i_clk); while (o_busy);
    endtask

    initial begin
        t_req_row row;
        int       sent;
        int       burst_left;
        int       gap;
        int       lean_left;
        bit       fill_lean;
        int       roll;
        int       pause_at;

        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_mode       = cdq_pkg::MODE_PUSH_FRONT;
        i_push_value = '0;
        row_typed    = 1'b0;
        row_rv       = '0;
        row_st       = cdq_pkg::ST_DONE;
        dq_head      = '0;
        dq_tail      = '0;
        dq_empty     = 1'b1;
        mismatches   = 0;
        cycles       = 0;
        for (int i = 0; i < DEPTH; i++)
            dq_store[i] = '0;

        // Empty-deque reads, a single entry in and out, ignored modes,
        // filling from both ends with extreme words, pushes when full, then peeks and pops.
        script[0]  = '{cdq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0,
                       cdq_pkg::ST_EMPTY};
        script[1]  = '{cdq_pkg::MODE_PEEK_REAR,  32'hFFFF_FFFF, 1'b1, 32'h0,
                       cdq_pkg::ST_EMPTY};
        script[2]  = '{cdq_pkg::MODE_POP_REAR,   32'h0000_0000, 1'b1, 32'h0,
                       cdq_pkg::ST_EMPTY};
        script[3]  = '{cdq_pkg::MODE_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h0,
                       cdq_pkg::ST_EMPTY};
        script[4]  = '{cdq_pkg::MODE_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0,
                       cdq_pkg::ST_DONE};
        script[5]  = '{cdq_pkg::MODE_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF,
                       cdq_pkg::ST_DONE};
        script[6]  = '{cdq_pkg::MODE_POP_REAR,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF,
                       cdq_pkg::ST_DONE};
        script[7]  = '{MODE_RSVD_6,              32'hDEAD_BEEF, 1'b1, 32'h0,
                       cdq_pkg::ST_DONE};
        script[8]  = '{MODE_RSVD_7,              32'hFFFF_FFFF, 1'b1, 32'h0,
                       cdq_pkg::ST_DONE};
        script[9]  = '{cdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[10] = '{cdq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[11] = '{cdq_pkg::MODE_PUSH_REAR,  32'h0000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[12] = '{cdq_pkg::MODE_PUSH_FRONT, 32'h5555_5555, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[13] = '{cdq_pkg::MODE_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[14] = '{cdq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[15] = '{cdq_pkg::MODE_PUSH_REAR,  32'h0000_0001, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[16] = '{cdq_pkg::MODE_PUSH_REAR,  32'h8000_0001, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[17] = '{cdq_pkg::MODE_PUSH_REAR,  32'h1234_5678, 1'b1, 32'h0,
                       cdq_pkg::ST_FULL};
        script[18] = '{cdq_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'h0,
                       cdq_pkg::ST_FULL};
        script[19] = '{cdq_pkg::MODE_PEEK_FRONT, 32'h0000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[20] = '{cdq_pkg::MODE_PEEK_REAR,  32'h0000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[21] = '{cdq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};
        script[22] = '{cdq_pkg::MODE_POP_REAR,   32'h0000_0000, 1'b0, 32'h0,
                       cdq_pkg::ST_DONE};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_SCRIPT; i++)
            send_beat(script[i]);

        // Random part: stretches that lean toward filling or draining, so the
        // deque keeps crossing between empty and full from both ends.
        sent       = 0;
        burst_left = 0;
        lean_left  = 0;
        fill_lean  = 1'b1;
        pause_at   = $urandom_range(N_RANDOM / 3, 2 * N_RANDOM / 3);
        while (sent < N_RANDOM) begin
            if (lean_left == 0) begin
                lean_left = $urandom_range(4, 30);
                fill_lean = ~fill_lean;
            end
            lean_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                row.mode = ($urandom_range(0, 1) != 0) ? MODE_RSVD_7 : MODE_RSVD_6;
            else if (roll < (fill_lean ? 63 : 28))
                row.mode = ($urandom_range(0, 1) != 0) ? cdq_pkg::MODE_PUSH_REAR
                                                       : cdq_pkg::MODE_PUSH_FRONT;
            else if (roll < 88)
                row.mode = ($urandom_range(0, 1) != 0) ? cdq_pkg::MODE_POP_REAR
                                                       : cdq_pkg::MODE_POP_FRONT;
            else
                row.mode = ($urandom_range(0, 1) != 0) ? cdq_pkg::MODE_PEEK_REAR
                                                       : cdq_pkg::MODE_PEEK_FRONT;
            case ($urandom_range(0, 15))
                0:       row.value = 32'h8000_0000;
                1:       row.value = 32'h7FFF_FFFF;
                2:       row.value = 32'hFFFF_FFFF;
                3:       row.value = 32'h0000_0000;
                default: row.value = $urandom;
            endcase
            row.typed = 1'b0;
            row.rv    = '0;
            row.st    = cdq_pkg::ST_DONE;
            send_beat(row);
            if (row.mode != MODE_RSVD_6 && row.mode != MODE_RSVD_7)
                sent++;

            if (sent == pause_at) begin
                @(negedge i_clk);
                i_start = 1'b0;
                while (pending.size() != 0) @(negedge i_clk);
                pause_at = -1;
            end else if (burst_left == 0) begin
                // Long bursts run back to back; otherwise a gap that lands
                // anywhere within the block's busy window or beyond it.
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
                gap = $urandom_range(1, 2 * DEPTH + 2);
                @(negedge i_clk);
                i_start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end

        @(negedge i_clk);
        i_start = 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 2) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
